// ===== src/bau_pkg.sv =====
// Shared types, constants and register codes of the battery alarm annunciator.
`default_nettype none

package bau_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_CLEAR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_ARM       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_MIN_HOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_MAX_HOLD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_BEEP     = 3'd5;

    // Item actions
    localparam logic [1:0] ACT_UPDATE    = 2'd0;
    localparam logic [1:0] ACT_SET_MUTE  = 2'd1;
    localparam logic [1:0] ACT_SET_QUIET = 2'd2;

    // Priority levels
    localparam logic [1:0] LVL_OK       = 2'd0;
    localparam logic [1:0] LVL_WATCH    = 2'd1;
    localparam logic [1:0] LVL_ALARM    = 2'd2;
    localparam logic [1:0] LVL_CRITICAL = 2'd3;

    // Blink periods in milliseconds
    localparam logic [31:0] WATCH_FLASH_MS = 32'd1000;
    localparam logic [31:0] ALARM_FLASH_MS = 32'd250;
    localparam logic [31:0] FAULT_FLASH_MS = 32'd600;

    // LED intensities
    localparam logic [6:0] LED_FULL        = 7'd80;
    localparam logic [6:0] LED_WATCH_RED   = 7'd70;
    localparam logic [6:0] LED_WATCH_GREEN = 7'd45;
    localparam logic [6:0] LED_IDLE_GREEN  = 7'd12;

    localparam logic [15:0] EVENT_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [11:0] RST_CRIT_TEMP     = 12'd600;
    localparam logic [11:0] RST_CRIT_CLEAR    = 12'd550;
    localparam logic [15:0] RST_MUTE_ARM      = 16'd3000;
    localparam logic [15:0] RST_MUTE_MIN_HOLD = 16'd600;
    localparam logic [15:0] RST_MUTE_MAX_HOLD = 16'd5000;
    localparam logic [15:0] RST_QUIET_BEEP    = 16'd100;

    typedef struct packed {
        logic signed [11:0] critical_temp;
        logic signed [11:0] critical_clear_temp;
        logic [15:0]        mute_arm_ms;
        logic [15:0]        mute_min_hold_ms;
        logic [15:0]        mute_max_hold_ms;
        logic [15:0]        quiet_beep_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         action;
        logic               flag_value;
        logic [31:0]        now_ms;
        logic               cls_alarm;
        logic               cls_watch;
        logic               temp_valid;
        logic signed [11:0] temp_tenths;
        logic               sensor_fault;
        logic               button_down;
    } t_item;

    typedef struct packed {
        logic [1:0]  level;
        logic [6:0]  led_red;
        logic [6:0]  led_green;
        logic [6:0]  led_blue;
        logic        buzzer_on;
        logic        is_muted;
        logic        is_quiet;
        logic [15:0] alarm_events;
    } t_result;

endpackage

`default_nettype wire

// ===== src/bau_cfg.sv =====
// Configuration register file of the battery alarm annunciator.
`default_nettype none

module bau_cfg
    import bau_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [15:0]          i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Load the addressed register on a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.critical_temp       <= RST_CRIT_TEMP;
            r_cfg.critical_clear_temp <= RST_CRIT_CLEAR;
            r_cfg.mute_arm_ms         <= RST_MUTE_ARM;
            r_cfg.mute_min_hold_ms    <= RST_MUTE_MIN_HOLD;
            r_cfg.mute_max_hold_ms    <= RST_MUTE_MAX_HOLD;
            r_cfg.quiet_beep_ms       <= RST_QUIET_BEEP;
        end else if (i_wr) begin
            case (i_index)
                CFG_CRIT_TEMP:     r_cfg.critical_temp       <= i_data[11:0];
                CFG_CRIT_CLEAR:    r_cfg.critical_clear_temp <= i_data[11:0];
                CFG_MUTE_ARM:      r_cfg.mute_arm_ms         <= i_data;
                CFG_MUTE_MIN_HOLD: r_cfg.mute_min_hold_ms    <= i_data;
                CFG_MUTE_MAX_HOLD: r_cfg.mute_max_hold_ms    <= i_data;
                CFG_QUIET_BEEP:    r_cfg.quiet_beep_ms       <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/bau_core.sv =====
// Alarm state registers with the per-item update and result logic.
`default_nettype none

module bau_core
    import bau_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_advance,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    logic        r_crit, n_crit;
    logic [1:0]  r_level, n_level;
    logic        r_fault, n_fault;
    logic        r_phase, n_phase;
    logic [31:0] r_bstamp, n_bstamp;
    logic        r_mute, n_mute;
    logic        r_quiet, n_quiet;
    logic        r_rel, n_rel;
    logic        r_pend, n_pend;
    logic [31:0] r_pstamp, n_pstamp;
    logic [15:0] r_events, n_events;

    logic        mute_tog;
    logic [31:0] held;
    logic [31:0] period;
    logic [31:0] blink_age;
    logic [31:0] out_age;
    logic        gate;

    // Next state for one item
    always_comb begin
        n_crit   = r_crit;
        n_level  = r_level;
        n_fault  = r_fault;
        n_phase  = r_phase;
        n_bstamp = r_bstamp;
        n_mute   = r_mute;
        n_quiet  = r_quiet;
        n_rel    = r_rel;
        n_pend   = r_pend;
        n_pstamp = r_pstamp;
        n_events = r_events;
        mute_tog = 1'b0;
        held     = i_item.now_ms - r_pstamp;
        period   = '0;
        blink_age = '0;

        case (i_item.action)
            ACT_SET_MUTE:  n_mute  = i_item.flag_value;
            ACT_SET_QUIET: n_quiet = i_item.flag_value;
            ACT_UPDATE: begin
                // Mute button: arm window, seen-released check, hold limits
                if (i_item.now_ms < {16'd0, i_cfg.mute_arm_ms}) begin
                    n_pend = 1'b0;
                end else if (!r_rel) begin
                    if (!i_item.button_down) n_rel = 1'b1;
                    n_pend = 1'b0;
                end else if (i_item.button_down) begin
                    if (!r_pend) begin
                        n_pend   = 1'b1;
                        n_pstamp = i_item.now_ms;
                    end
                end else if (r_pend) begin
                    n_pend = 1'b0;
                    if (!(held < {16'd0, i_cfg.mute_min_hold_ms} ||
                          held > {16'd0, i_cfg.mute_max_hold_ms}))
                        mute_tog = 1'b1;
                end
                n_mute = r_mute ^ mute_tog;

                // Critical latch with hysteresis; missing reading holds it
                if (i_item.temp_valid) begin
                    if (i_item.temp_tenths >= i_cfg.critical_temp)
                        n_crit = 1'b1;
                    else if (i_item.temp_tenths < i_cfg.critical_clear_temp)
                        n_crit = 1'b0;
                end

                if (n_crit)                n_level = LVL_CRITICAL;
                else if (i_item.cls_alarm) n_level = LVL_ALARM;
                else if (i_item.cls_watch) n_level = LVL_WATCH;
                else                       n_level = LVL_OK;
                n_fault = i_item.sensor_fault;

                // Rising level cancels mute and quiet
                if (n_level > r_level) begin
                    n_mute  = 1'b0;
                    n_quiet = 1'b0;
                end
                if (n_level >= LVL_ALARM && r_level < LVL_ALARM && r_events != EVENT_MAX)
                    n_events = r_events + 16'd1;

                // Blinker
                case (n_level)
                    LVL_WATCH:    period = WATCH_FLASH_MS;
                    LVL_ALARM:    period = ALARM_FLASH_MS;
                    LVL_CRITICAL: period = '0;
                    default:      period = n_fault ? FAULT_FLASH_MS : '0;
                endcase
                blink_age = i_item.now_ms - r_bstamp;
                if (period == '0) begin
                    n_phase = 1'b1;
                end else if (blink_age >= period) begin
                    n_bstamp = i_item.now_ms;
                    n_phase  = !r_phase;
                end
            end
            default: ;
        endcase
    end

    // Result from the updated state
    always_comb begin
        o_result.level        = n_level;
        o_result.led_red      = '0;
        o_result.led_green    = '0;
        o_result.led_blue     = '0;
        o_result.is_muted     = n_mute;
        o_result.is_quiet     = n_quiet;
        o_result.alarm_events = n_events;
        case (n_level)
            LVL_CRITICAL: o_result.led_red = LED_FULL;
            LVL_ALARM:    o_result.led_red = n_phase ? LED_FULL : 7'd0;
            LVL_WATCH: begin
                o_result.led_red   = n_phase ? LED_WATCH_RED : 7'd0;
                o_result.led_green = n_phase ? LED_WATCH_GREEN : 7'd0;
            end
            default: begin
                if (n_fault) o_result.led_blue  = n_phase ? LED_FULL : 7'd0;
                else         o_result.led_green = LED_IDLE_GREEN;
            end
        endcase
        out_age = i_item.now_ms - n_bstamp;
        gate = !n_quiet || (n_level == LVL_CRITICAL) ||
               (out_age < {16'd0, i_cfg.quiet_beep_ms});
        o_result.buzzer_on = (n_level >= LVL_ALARM) && !n_mute && n_phase && gate;
    end

    // Hold state; advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit   <= 1'b0;
            r_level  <= LVL_OK;
            r_fault  <= 1'b0;
            r_phase  <= 1'b0;
            r_bstamp <= '0;
            r_mute   <= 1'b0;
            r_quiet  <= 1'b0;
            r_rel    <= 1'b0;
            r_pend   <= 1'b0;
            r_pstamp <= '0;
            r_events <= '0;
        end else if (i_advance) begin
            r_crit   <= n_crit;
            r_level  <= n_level;
            r_fault  <= n_fault;
            r_phase  <= n_phase;
            r_bstamp <= n_bstamp;
            r_mute   <= n_mute;
            r_quiet  <= n_quiet;
            r_rel    <= n_rel;
            r_pend   <= n_pend;
            r_pstamp <= n_pstamp;
            r_events <= n_events;
        end
    end

endmodule

`default_nettype wire

// ===== src/battery_alarm_annunciator_unit.sv =====
// Top level of the battery alarm annunciator: handshake, input and result registers.
//
//  channel   direction  payload                         transfer when
//  s_axis    in         tuser action, tdata item        i_s_tvalid & o_s_tready
//  m_axis    out        tdata result                    o_m_tvalid & i_m_tready
//  cfg       in         index 3b, data 16b              i_cfg_valid & o_cfg_ready
//
// An item is held in the input register and its result is captured in the result
// register, one item per cycle while the result register is not stalled.
// The result register stalls on i_m_tready; the input register then fills and
// o_s_tready drops until the result is taken. Config is always ready.
// Synchronous reset empties both registers and restores all state.
`default_nettype none

module battery_alarm_annunciator_unit
    import bau_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // tdata: flag_value, now_ms[31:0], cls_alarm, cls_watch, temp_valid,
    //        temp_tenths[11:0], sensor_fault, button_down, 6 zero bits
    input  wire logic [55:0]          i_s_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata: level[1:0], led_red[6:0], led_green[6:0], led_blue[6:0], buzzer_on,
    //        is_muted, is_quiet, alarm_events[15:0], 6 zero bits
    output logic [47:0]               o_m_tdata,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    t_cfg    cfg;
    t_item   r_item;
    t_result core_res;
    t_result r_res;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;
    logic    in_xfer;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign in_xfer     = i_s_tvalid && o_s_tready;

    bau_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bau_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (core_res)
    );

    // Input register valid and result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer)      r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance)                      r_out_valid <= 1'b1;
            else if (i_m_tready)              r_out_valid <= 1'b0;
        end
    end

    // Unpack an accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.action       <= i_s_tuser;
            r_item.flag_value   <= i_s_tdata[0];
            r_item.now_ms       <= i_s_tdata[32:1];
            r_item.cls_alarm    <= i_s_tdata[33];
            r_item.cls_watch    <= i_s_tdata[34];
            r_item.temp_valid   <= i_s_tdata[35];
            r_item.temp_tenths  <= i_s_tdata[47:36];
            r_item.sensor_fault <= i_s_tdata[48];
            r_item.button_down  <= i_s_tdata[49];
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (advance) r_res <= core_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_res.alarm_events, r_res.is_quiet, r_res.is_muted,
                         r_res.buzzer_on, r_res.led_blue, r_res.led_green,
                         r_res.led_red, r_res.level};

endmodule

`default_nettype wire

// ===== src/bau_checker.sv =====
// Port-level checks of the battery alarm annunciator, bound to the top level.
`default_nettype none

module bau_checker
    import bau_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [47:0] o_m_tdata
);

    // Stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Buzzer only sounds at alarm or above and when not muted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[23] |-> o_m_tdata[1] && !o_m_tdata[24])
        else $error("buzzer on below alarm or while muted");

    // Critical level shows steady full red
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == LVL_CRITICAL |->
            o_m_tdata[8:2] == LED_FULL && o_m_tdata[22:9] == 14'd0)
        else $error("wrong colour at critical level");

endmodule

bind battery_alarm_annunciator_unit bau_checker u_bau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
